>>> sv/icds_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the I2C clock divider search.
// No dependencies; used by every other file of the block.

package icds_pkg;

  // Module clock the dividers are derived from, in kHz.
  localparam int unsigned ModuleClockKhz = 13000;

  localparam int unsigned SpeedW     = 12;
  localparam int unsigned SampleW    = 3;
  localparam int unsigned SampleMax  = 8;
  localparam int unsigned FastStepW  = 6;
  localparam int unsigned HighStepW  = 3;
  localparam int unsigned FastLimit  = 64;
  localparam int unsigned HighLimit  = 8;

  // speed * 2 * sample, sample up to 8
  localparam int unsigned DenomW = SpeedW + 4;
  // step divider 1..64
  localparam int unsigned QuotW  = FastStepW + 1;
  localparam int unsigned BitW   = $clog2(QuotW);
  localparam int unsigned ClkW   = $clog2(ModuleClockKhz + 1);
  // clock + denom - 1
  localparam int unsigned NumW   = ((ClkW > DenomW) ? ClkW : DenomW) + 1;
  // denom scaled by the fast limit, compared with the clock
  localparam int unsigned ProdW  = DenomW + FastStepW;
  localparam int unsigned CmpW   = (ProdW > ClkW) ? ProdW : ClkW;
  // denom shifted by a quotient bit, compared with the remainder
  localparam int unsigned DivW   = ((NumW > DenomW + QuotW) ? NumW : DenomW + QuotW);

  typedef enum logic {
    LaneFast,
    LaneHigh
  } lane_mode_e;

  // Lane status toward the merge stage.
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SampleW-1:0] sample_m1;
    logic [QuotW-1:0]   step;
  } lane_stat_t;

endpackage

>>> sv/icds_lane.sv
`timescale 1ns / 1ps
// One search lane: walks sample dividers 1..8, then a restoring divide for the step.
// Depends on icds_pkg.

module icds_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  icds_pkg::lane_mode_e          mode_i,
  input  logic                          start_i,
  input  logic [icds_pkg::SpeedW-1:0]   speed_i,
  input  logic                          ack_i,
  output icds_pkg::lane_stat_t          stat_o
);

  typedef enum logic [1:0] {
    StIdle,
    StTry,
    StDiv,
    StDone
  } state_e;

  state_e                         state_q;
  logic [icds_pkg::SpeedW:0]      speed2_q;
  logic [icds_pkg::DenomW-1:0]    denom_q;
  logic [icds_pkg::SampleW-1:0]   sample_q;
  logic [icds_pkg::NumW-1:0]      rem_q;
  logic [icds_pkg::QuotW-1:0]     quot_q;
  logic [icds_pkg::BitW-1:0]      bit_q;

  logic [icds_pkg::SpeedW-1:0]    speed_fix;
  logic [icds_pkg::CmpW-1:0]      scaled;
  logic                           fits;
  logic [icds_pkg::DivW-1:0]      trial;
  logic                           sub_ok;
  logic [icds_pkg::QuotW-1:0]     limit;

  always_comb begin
    speed_fix = (speed_i == '0) ? icds_pkg::SpeedW'(1) : speed_i;
    if (mode_i == icds_pkg::LaneHigh) begin
      scaled = icds_pkg::CmpW'(denom_q) << icds_pkg::HighStepW;
      limit  = icds_pkg::QuotW'(icds_pkg::HighLimit);
    end else begin
      scaled = icds_pkg::CmpW'(denom_q) << icds_pkg::FastStepW;
      limit  = icds_pkg::QuotW'(icds_pkg::FastLimit);
    end
    // ceil(clk / denom) <= limit  <=>  clk <= limit * denom
    fits   = scaled >= icds_pkg::CmpW'(icds_pkg::ModuleClockKhz);
    trial  = icds_pkg::DivW'(denom_q) << bit_q;
    sub_ok = icds_pkg::DivW'(rem_q) >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      speed2_q <= '0;
      denom_q  <= '0;
      sample_q <= '0;
      rem_q    <= '0;
      quot_q   <= '0;
      bit_q    <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            speed2_q <= {speed_fix, 1'b0};
            denom_q  <= icds_pkg::DenomW'({speed_fix, 1'b0});
            sample_q <= '0;
            state_q  <= StTry;
          end
        end
        StTry: begin
          if (fits) begin
            rem_q   <= icds_pkg::NumW'(icds_pkg::ModuleClockKhz)
                       + icds_pkg::NumW'(denom_q) - icds_pkg::NumW'(1);
            quot_q  <= '0;
            bit_q   <= icds_pkg::BitW'(icds_pkg::QuotW - 1);
            state_q <= StDiv;
          end else if (sample_q == icds_pkg::SampleW'(icds_pkg::SampleMax - 1)) begin
            // nothing fits: saturate
            quot_q  <= limit;
            state_q <= StDone;
          end else begin
            sample_q <= sample_q + 1'b1;
            denom_q  <= denom_q + icds_pkg::DenomW'(speed2_q);
          end
        end
        StDiv: begin
          if (sub_ok) begin
            rem_q         <= icds_pkg::NumW'(icds_pkg::DivW'(rem_q) - trial);
            quot_q[bit_q] <= 1'b1;
          end
          if (bit_q == '0) begin
            state_q <= StDone;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        StDone: begin
          if (ack_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign stat_o.busy      = (state_q != StIdle);
  assign stat_o.done      = (state_q == StDone);
  assign stat_o.sample_m1 = sample_q;
  assign stat_o.step      = quot_q;

endmodule

>>> sv/icds_merge.sv
`timescale 1ns / 1ps
// Merge stage: joins both lanes into one result beat held in an output register.
// Depends on icds_pkg.

module icds_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  icds_pkg::lane_stat_t             fast_i,
  input  icds_pkg::lane_stat_t             high_i,
  output logic                             ack_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [icds_pkg::SampleW-1:0]     fast_sample_div_o,
  output logic [icds_pkg::FastStepW-1:0]   fast_step_div_o,
  output logic [icds_pkg::SampleW-1:0]     high_sample_div_o,
  output logic [icds_pkg::HighStepW-1:0]   high_step_div_o
);

  logic                             valid_q;
  logic [icds_pkg::SampleW-1:0]     fs_sample_q;
  logic [icds_pkg::FastStepW-1:0]   fs_step_q;
  logic [icds_pkg::SampleW-1:0]     hs_sample_q;
  logic [icds_pkg::HighStepW-1:0]   hs_step_q;
  logic [icds_pkg::QuotW-1:0]       fs_step_m1;
  logic [icds_pkg::QuotW-1:0]       hs_step_m1;
  logic                             capture;

  assign capture    = fast_i.done && high_i.done && (!valid_q || !out_stall_i);
  assign fs_step_m1 = fast_i.step - icds_pkg::QuotW'(1);
  assign hs_step_m1 = high_i.step - icds_pkg::QuotW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (capture) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      fs_sample_q <= fast_i.sample_m1;
      fs_step_q   <= fs_step_m1[icds_pkg::FastStepW-1:0];
      hs_sample_q <= high_i.sample_m1;
      hs_step_q   <= hs_step_m1[icds_pkg::HighStepW-1:0];
    end
  end

  assign ack_o             = capture;
  assign out_valid_o       = valid_q;
  assign fast_sample_div_o = fs_sample_q;
  assign fast_step_div_o   = fs_step_q;
  assign high_sample_div_o = hs_sample_q;
  assign high_step_div_o   = hs_step_q;

endmodule

>>> sv/i2c_clock_divider_search_top.sv
`timescale 1ns / 1ps
// Top level of the I2C clock divider search: two search lanes and a merge stage.
// Depends on icds_pkg, icds_lane and icds_merge.

// Turns a fast-mode and a high-speed-mode bus speed (kHz, zero counts as 1 kHz)
// into the sample/step divider pairs of an I2C controller, both reported minus
// one. Each speed has its own lane; both lanes run side by side on one input beat.
// A lane tries sample dividers 1..8, one per cycle, checking whether the step
// divider ceil(clock / (speed*2*sample)) is within the limit (64 fast, 8 high
// speed) with a shift and compare, then derives the step divider with a restoring
// divide. If no sample fits, the pair saturates to 8 / limit. One beat is in the
// lanes at a time: in_stall_o is high while either lane is busy, and drops at the
// same edge at which the output register loads. The finished result sits in the
// output register, so the next beat can be taken while the previous result is
// still stalled downstream.

module i2c_clock_divider_search_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [icds_pkg::SpeedW-1:0]      fast_speed_khz_i,
  input  logic [icds_pkg::SpeedW-1:0]      high_speed_khz_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [icds_pkg::SampleW-1:0]     fast_sample_div_o,
  output logic [icds_pkg::FastStepW-1:0]   fast_step_div_o,
  output logic [icds_pkg::SampleW-1:0]     high_sample_div_o,
  output logic [icds_pkg::HighStepW-1:0]   high_step_div_o
);

  icds_pkg::lane_stat_t fast_stat;
  icds_pkg::lane_stat_t high_stat;
  logic                 start;
  logic                 ack;

  // Lanes hold their result until the merge stage takes both at once.
  assign in_stall_o = fast_stat.busy | high_stat.busy;
  assign start      = in_valid_i & ~in_stall_o;

  icds_lane u_lane_fast (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (icds_pkg::LaneFast),
    .start_i (start),
    .speed_i (fast_speed_khz_i),
    .ack_i   (ack),
    .stat_o  (fast_stat)
  );

  icds_lane u_lane_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (icds_pkg::LaneHigh),
    .start_i (start),
    .speed_i (high_speed_khz_i),
    .ack_i   (ack),
    .stat_o  (high_stat)
  );

  icds_merge u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fast_i            (fast_stat),
    .high_i            (high_stat),
    .ack_o             (ack),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .fast_sample_div_o (fast_sample_div_o),
    .fast_step_div_o   (fast_step_div_o),
    .high_sample_div_o (high_sample_div_o),
    .high_step_div_o   (high_step_div_o)
  );

endmodule

>>> sv/icds_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the I2C clock divider search, bound to the top level.
// Depends on icds_pkg and i2c_clock_divider_search_top.

module icds_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic [icds_pkg::SampleW-1:0]     fast_sample_div_o,
  input  logic [icds_pkg::FastStepW-1:0]   fast_step_div_o,
  input  logic [icds_pkg::SampleW-1:0]     high_sample_div_o,
  input  logic [icds_pkg::HighStepW-1:0]   high_step_div_o
);

  // stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fast_step_div_o) && $stable(high_step_div_o)
      && $stable(fast_sample_div_o) && $stable(high_sample_div_o))
    else $error("stalled result changed");

  // a taken beat makes the lanes busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a larger sample divider means the smaller one overflowed: step is in upper half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fast_sample_div_o != '0 |-> fast_step_div_o[icds_pkg::FastStepW-1])
    else $error("fast step divider too small for its sample divider");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && high_sample_div_o != '0 |-> high_step_div_o[icds_pkg::HighStepW-1])
    else $error("high-speed step divider too small for its sample divider");

endmodule

bind i2c_clock_divider_search_top icds_checker u_icds_checker (.*);

>>> test/i2c_clock_divider_search_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for i2c_clock_divider_search_top: speed pairs in, divider pairs out.
// Depends on icds_pkg and the RTL of the block; nothing else is read or needed.

module i2c_clock_divider_search_top_tb;

  // One requested speed pair; wait_drain holds the beat back until every
  // earlier result has come out.
  typedef struct {
    logic [icds_pkg::SpeedW-1:0] fast_khz;
    logic [icds_pkg::SpeedW-1:0] high_khz;
    bit                          wait_drain;
  } speed_req_t;

  typedef struct packed {
    logic [icds_pkg::SampleW-1:0]   fast_sample;
    logic [icds_pkg::FastStepW-1:0] fast_step;
    logic [icds_pkg::SampleW-1:0]   high_sample;
    logic [icds_pkg::HighStepW-1:0] high_step;
  } divider_set_t;

  localparam int unsigned RandomBeats = 600;
  localparam int unsigned HoldStart   = 320;  // beats sent before the long receiver hold-off
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned QuietFirst  = 450;  // window of beats with no idling on either side
  localparam int unsigned QuietLast   = 540;
  localparam int unsigned TailCycles  = 40;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall_o;
  logic [icds_pkg::SpeedW-1:0]     fast_speed_khz = '0;
  logic [icds_pkg::SpeedW-1:0]     high_speed_khz = '0;
  logic                            out_valid_o;
  logic                            out_stall = 1'b1;
  logic [icds_pkg::SampleW-1:0]    fast_sample_div_o;
  logic [icds_pkg::FastStepW-1:0]  fast_step_div_o;
  logic [icds_pkg::SampleW-1:0]    high_sample_div_o;
  logic [icds_pkg::HighStepW-1:0]  high_step_div_o;

  speed_req_t   speed_req_q[$];
  divider_set_t divider_exp_q[$];

  int unsigned sent_cnt;
  int unsigned checked_cnt;
  int unsigned saturated_cnt;
  int unsigned error_cnt;
  int unsigned hold_left;
  bit          hold_armed;

  i2c_clock_divider_search_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .fast_speed_khz_i  (fast_speed_khz),
    .high_speed_khz_i  (high_speed_khz),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .fast_sample_div_o (fast_sample_div_o),
    .fast_step_div_o   (fast_step_div_o),
    .high_sample_div_o (high_sample_div_o),
    .high_step_div_o   (high_step_div_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Divider search for one lane: walk sample dividers 1..8 and keep the first
  // whose step divider ceil(clock / (speed*2*sample)) is within the lane limit.
  // A zero speed counts as 1 kHz; no fit saturates to 8 / limit.
  function automatic void search_divider(input int unsigned speed, input int unsigned limit,
                                         output int unsigned sample_m1,
                                         output int unsigned step_m1);
    int unsigned spd;
    int unsigned denom;
    int unsigned quot;
    int unsigned try_div;
    bit          hit;
    spd       = (speed == 0) ? 1 : speed;
    hit       = 1'b0;
    sample_m1 = icds_pkg::SampleMax - 1;
    step_m1   = limit - 1;
    for (try_div = 1; try_div <= icds_pkg::SampleMax && !hit; try_div++) begin
      denom = spd * 2 * try_div;
      quot  = (icds_pkg::ModuleClockKhz + denom - 1) / denom;
      if (quot == 0) quot = 1;  // cannot occur for a nonzero clock
      if (quot <= limit) begin
        hit       = 1'b1;
        sample_m1 = try_div - 1;
        step_m1   = quot - 1;
      end
    end
  endfunction

  function automatic divider_set_t predict_dividers(
      input logic [icds_pkg::SpeedW-1:0] fast_khz,
      input logic [icds_pkg::SpeedW-1:0] high_khz);
    divider_set_t res;
    int unsigned  smp;
    int unsigned  stp;
    search_divider(fast_khz, icds_pkg::FastLimit, smp, stp);
    res.fast_sample = smp[icds_pkg::SampleW-1:0];
    res.fast_step   = stp[icds_pkg::FastStepW-1:0];
    search_divider(high_khz, icds_pkg::HighLimit, smp, stp);
    res.high_sample = smp[icds_pkg::SampleW-1:0];
    res.high_step   = stp[icds_pkg::HighStepW-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    error_cnt++;
    $display("%0t ERROR %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Random idling with odds of about 15 in 100, except inside the quiet window and,
  // for the sender, while the receiver is holding off (so the block backs up).
  function automatic bit idle_now();
    if (sent_cnt >= QuietFirst && sent_cnt < QuietLast) return 1'b0;
    return ($urandom_range(99) < 15);
  endfunction

  // Long receiver hold-off, counted down here from HoldCycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && sent_cnt == HoldStart) begin
      hold_left  <= HoldCycles;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Driver: a beat moves when valid is high and stall is low; the payload holds
  // while stalled. The expectation is queued at the accepting edge.
  always @(posedge clk_i or negedge rst_ni) begin
    speed_req_t req;
    bit         take;
    if (!rst_ni) begin
      in_valid       <= 1'b0;
      fast_speed_khz <= '0;
      high_speed_khz <= '0;
    end else begin
      take = 1'b0;
      if (in_valid && !in_stall_o) begin
        divider_exp_q.push_back(predict_dividers(fast_speed_khz, high_speed_khz));
        sent_cnt++;
      end
      if (!in_valid || !in_stall_o) begin
        if (speed_req_q.size() != 0 && (hold_left != 0 || !idle_now())) begin
          take = !(speed_req_q[0].wait_drain && divider_exp_q.size() != 0);
        end
        if (take) begin
          req = speed_req_q.pop_front();
          fast_speed_khz <= req.fast_khz;
          high_speed_khz <= req.high_khz;
        end
        in_valid <= take;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation and
  // pick the stall for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    divider_set_t want;
    if (!rst_ni) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (divider_exp_q.size() == 0) begin
          flag_mismatch("result beats with nothing expected", 1, 0);
        end else begin
          want = divider_exp_q.pop_front();
          checked_cnt++;
          if (want.fast_sample == icds_pkg::SampleMax - 1
              && want.fast_step == icds_pkg::FastLimit - 1)
            saturated_cnt++;
          if (fast_sample_div_o !== want.fast_sample)
            flag_mismatch("fast_sample_div", fast_sample_div_o, want.fast_sample);
          if (fast_step_div_o !== want.fast_step)
            flag_mismatch("fast_step_div", fast_step_div_o, want.fast_step);
          if (high_sample_div_o !== want.high_sample)
            flag_mismatch("high_sample_div", high_sample_div_o, want.high_sample);
          if (high_step_div_o !== want.high_step)
            flag_mismatch("high_step_div", high_step_div_o, want.high_step);
        end
      end
      out_stall <= (hold_left != 0) || idle_now();
    end
  end

  task automatic queue_speeds(input int unsigned fast_khz, input int unsigned high_khz,
                              input bit wait_drain);
    speed_req_t req;
    req.fast_khz   = fast_khz[icds_pkg::SpeedW-1:0];
    req.high_khz   = high_khz[icds_pkg::SpeedW-1:0];
    req.wait_drain = wait_drain;
    speed_req_q.push_back(req);
  endtask

  // Stimulus and end of run.
  initial begin
    int unsigned pick;
    int unsigned fk;
    int unsigned hk;

    // Directed: zero speeds, extremes, and the points where each lane goes
    // from saturated to fitting and where sample divider 1 just fits.
    queue_speeds(0, 0, 1'b0);
    queue_speeds(1, 1, 1'b0);
    queue_speeds(4095, 4095, 1'b0);
    queue_speeds(0, 4095, 1'b0);
    queue_speeds(4095, 0, 1'b0);
    queue_speeds(12, 101, 1'b0);     // last saturating speeds
    queue_speeds(13, 102, 1'b0);     // first fit, sample divider 8
    queue_speeds(101, 812, 1'b0);    // sample divider 1 just misses
    queue_speeds(102, 813, 1'b0);    // sample divider 1 just fits
    queue_speeds(100, 400, 1'b0);
    queue_speeds(2048, 2048, 1'b0);
    queue_speeds(12'hAAA, 12'h555, 1'b0);
    queue_speeds(12'h555, 12'hAAA, 1'b0);
    queue_speeds(400, 3400, 1'b0);
    queue_speeds(50, 200, 1'b0);
    queue_speeds(203, 1625, 1'b0);
    queue_speeds(204, 1626, 1'b0);
    queue_speeds(7, 50, 1'b0);
    queue_speeds(26, 3250, 1'b0);

    // Random: full range plus a bias toward the small speeds where the
    // search walks through many sample dividers or saturates.
    for (int unsigned n = 0; n < RandomBeats; n++) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        fk = $urandom_range(4095);
        hk = $urandom_range(4095);
      end else if (pick < 7) begin
        fk = $urandom_range(130);
        hk = $urandom_range(900);
      end else begin
        fk = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(20);
        hk = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(110);
      end
      queue_speeds(fk, hk, n == 0 || n == 200 || n == 480);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (speed_req_q.size() != 0 || in_valid) @(posedge clk_i);
    while (divider_exp_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (divider_exp_q.size() != 0) begin
      flag_mismatch("expected results never arrived", divider_exp_q.size(), 0);
    end
    $display("Sent %0d speed pairs, checked %0d divider results (%0d saturated in fast mode),",
             sent_cnt, checked_cnt, saturated_cnt);
    $display("with random stalls, a %0d-cycle receiver hold-off and drain pauses; %0d errors.",
             HoldCycles, error_cnt);
    if (error_cnt == 0) begin
      $display("i2c_clock_divider_search_top: match");
    end else begin
      $display("i2c_clock_divider_search_top: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout: run did not complete");
    $display("i2c_clock_divider_search_top: mismatch");
    $finish;
  end

endmodule
